@@ rtl/speck128_ofb_block_cipher_defines.svh @@
// Assertion macros for the Speck128 OFB cipher.
// Used by the top level; expects clk and rst_n in scope.
// Define NO_ASSERTIONS to compile them out.
`ifndef SPECK128_OFB_BLOCK_CIPHER_DEFINES_SVH
`define SPECK128_OFB_BLOCK_CIPHER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define SPK_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define SPK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SPK_ASSERT_SAME(lbl, ante, cons)

`define SPK_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/speck_ofb_pkg.sv @@
// Package for the Speck128 OFB cipher: widths, request codes, state encoding.
// No dependencies.

package speck_ofb_pkg;

    localparam int WORD_W          = 64;
    localparam int KEY_SLOTS       = 32;
    localparam int KEY_IDX_W       = 5;
    localparam int REQ_W           = 2;
    localparam int ROT_X           = 8;
    localparam int ROT_Y           = 3;
    localparam int ROUND_COUNT_DEF = 32;

    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 128;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD_KEY = 2'd0,
        REQ_LOAD_IV  = 2'd1,
        REQ_BLOCK    = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

endpackage

@@ rtl/speck_ofb_round.sv @@
// One Speck128 round: rotate, add, xor on the word pair.
// Depends on speck_ofb_pkg.

module speck_ofb_round
    import speck_ofb_pkg::*;
(
    input  logic [WORD_W-1:0] x_in,
    input  logic [WORD_W-1:0] y_in,
    input  logic [WORD_W-1:0] round_key,
    output logic [WORD_W-1:0] x_out,
    output logic [WORD_W-1:0] y_out
);

    logic [WORD_W-1:0] x_rot;
    logic [WORD_W-1:0] y_rot;

    assign x_rot = {x_in[ROT_X-1:0], x_in[WORD_W-1:ROT_X]};
    assign y_rot = {y_in[WORD_W-ROT_Y-1:0], y_in[WORD_W-1:WORD_W-ROT_Y]};
    assign x_out = (x_rot + y_in) ^ round_key;
    assign y_out = y_rot ^ x_out;

endmodule

@@ rtl/speck128_ofb_block_cipher.sv @@
// Speck128 block cipher in output feedback mode, one round per cycle unless stalled.
// Depends on speck_ofb_pkg, speck_ofb_round and the assertion macro header.
//
// Usage:
//   Input items arrive on s_axis; tuser carries the request kind. A load-key
//   item writes one 64-bit round key into slot key_index of the key store; a
//   load-IV item sets the feedback pair; a block item runs the feedback pair
//   through ROUND_COUNT rounds, keeps the result as the new feedback and
//   returns it xored with the item's two words on m_axis. Load items give no
//   output. A block item is accepted only while idle; the shared round unit
//   then runs one round per cycle, held only by the output stall below, and
//   the result goes into the output register as the last round ends. No new
//   item is taken until the rounds are done.
//   Round keys must be loaded before the first block; round i uses slot
//   i mod 32. Reset clears the feedback pair and the handshake state; the
//   key store keeps no reset value.
//   The result sits in an output register; loads are taken while it waits.
//   If the receiver still stalls when the next block finishes its rounds,
//   the block holds in its last round until the register frees.

`include "speck128_ofb_block_cipher_defines.svh"

module speck128_ofb_block_cipher
    import speck_ofb_pkg::*;
#(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // key_index [4:0], block_word0 [68:5], block_word1 [132:69], zero [135:133]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // req_type [1:0]
    input  logic [REQ_W-1:0]      s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_word0 [63:0], out_word1 [127:64]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int CNT_W  = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
    localparam int W0_LSB = KEY_IDX_W;
    localparam int W1_LSB = KEY_IDX_W + WORD_W;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [KEY_IDX_W-1:0]   key_addr_reg, key_addr_next;
    logic [KEY_IDX_W-1:0]   rd_addr;
    logic [WORD_W-1:0]      key_mem [KEY_SLOTS];
    logic [WORD_W-1:0]      key_q_reg;
    logic [WORD_W-1:0]      fb0_reg, fb0_next;
    logic [WORD_W-1:0]      fb1_reg, fb1_next;
    logic [WORD_W-1:0]      data0_reg, data0_next;
    logic [WORD_W-1:0]      data1_reg, data1_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0]  m_data_reg, m_data_next;

    logic                   in_acc;
    req_t                   req;
    logic [KEY_IDX_W-1:0]   in_key_idx;
    logic [WORD_W-1:0]      in_w0;
    logic [WORD_W-1:0]      in_w1;
    logic [WORD_W-1:0]      x_rnd;
    logic [WORD_W-1:0]      y_rnd;
    logic                   last_round;
    logic                   step;
    logic                   key_rd_en;

    assign in_acc     = s_axis_tvalid && s_axis_tready;
    assign req        = req_t'(s_axis_tuser);
    assign in_key_idx = s_axis_tdata[KEY_IDX_W-1:0];
    assign in_w0      = s_axis_tdata[W0_LSB +: WORD_W];
    assign in_w1      = s_axis_tdata[W1_LSB +: WORD_W];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign last_round = (cnt_reg == CNT_W'(ROUND_COUNT - 1));
    assign step       = (state_reg == ST_RUN) && (!last_round || !m_valid_reg || m_axis_tready);
    assign key_rd_en  = (state_reg == ST_IDLE) || step;
    assign rd_addr    = (state_reg == ST_RUN) ? key_addr_reg : '0;

    speck_ofb_round u_round (
        .x_in      (fb1_reg),
        .y_in      (fb0_reg),
        .round_key (key_q_reg),
        .x_out     (x_rnd),
        .y_out     (y_rnd)
    );

    // key store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (in_acc && req == REQ_LOAD_KEY)
        begin
            key_mem[in_key_idx] <= in_w0;
        end
        if (key_rd_en)
        begin
            key_q_reg <= key_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        key_addr_next = key_addr_reg;
        fb0_next      = fb0_reg;
        fb1_next      = fb1_reg;
        data0_next    = data0_reg;
        data1_next    = data1_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_data_next   = m_data_reg;

        if (in_acc)
        begin
            case (req)
                REQ_LOAD_IV:
                begin
                    fb0_next = in_w0;
                    fb1_next = in_w1;
                end
                REQ_BLOCK:
                begin
                    state_next    = ST_RUN;
                    cnt_next      = '0;
                    key_addr_next = KEY_IDX_W'(1);
                    data0_next    = in_w0;
                    data1_next    = in_w1;
                end
                default:
                begin
                end
            endcase
        end

        if (step)
        begin
            fb0_next      = y_rnd;
            fb1_next      = x_rnd;
            cnt_next      = cnt_reg + CNT_W'(1);
            key_addr_next = key_addr_reg + KEY_IDX_W'(1);
            if (last_round)
            begin
                state_next   = ST_IDLE;
                m_valid_next = 1'b1;
                m_data_next  = {x_rnd ^ data1_reg, y_rnd ^ data0_reg};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            key_addr_reg <= '0;
            fb0_reg      <= '0;
            fb1_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            key_addr_reg <= key_addr_next;
            fb0_reg      <= fb0_next;
            fb1_reg      <= fb1_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data0_reg  <= data0_next;
        data1_reg  <= data1_next;
        m_data_reg <= m_data_next;
    end

    `SPK_ASSERT_NEXT(a_block_starts_run, in_acc && req == REQ_BLOCK,
        state_reg == ST_RUN && cnt_reg == '0)
    `SPK_ASSERT_NEXT(a_load_stays_idle, in_acc && req != REQ_BLOCK, state_reg == ST_IDLE)
    `SPK_ASSERT_NEXT(a_run_continues, state_reg == ST_RUN && !last_round, state_reg == ST_RUN)
    `SPK_ASSERT_NEXT(a_no_spurious_out, state_reg == ST_IDLE && !m_valid_reg, !m_axis_tvalid)

endmodule

@@ tb/sv/tb.sv @@
// Testbench for speck128_ofb_block_cipher: directed and random key, IV and block items.
// A scoreboard class predicts the keystream; needs speck_ofb_pkg and the RTL only.
`timescale 1ns / 1ps

import speck_ofb_pkg::*;

class ofb_scoreboard;
    logic [WORD_W-1:0]     round_keys [KEY_SLOTS];
    logic [WORD_W-1:0]     feedback0;
    logic [WORD_W-1:0]     feedback1;
    logic [OUT_DATA_W-1:0] expected_q [$];
    int                    rounds;

    function new(int round_count);
        rounds    = round_count;
        feedback0 = '0;
        feedback1 = '0;
        foreach (round_keys[i])
            round_keys[i] = '0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // x is feedback word 1, y is feedback word 0
    function void note_input(logic [REQ_W-1:0] req, logic [KEY_IDX_W-1:0] slot,
                             logic [WORD_W-1:0] w0, logic [WORD_W-1:0] w1);
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        case (req)
            REQ_LOAD_KEY:
                round_keys[slot] = w0;
            REQ_LOAD_IV:
            begin
                feedback0 = w0;
                feedback1 = w1;
            end
            REQ_BLOCK:
            begin
                x = feedback1;
                y = feedback0;
                for (int i = 0; i < rounds; i++)
                begin
                    x = (x >> ROT_X) | (x << (WORD_W - ROT_X));
                    x = x + y;
                    x = x ^ round_keys[i % KEY_SLOTS];
                    y = (y << ROT_Y) | (y >> (WORD_W - ROT_Y));
                    y = y ^ x;
                end
                feedback0 = y;
                feedback1 = x;
                expected_q.push_back({x ^ w1, y ^ w0});
            end
            default:
                ;
        endcase
    endfunction

    function bit check_result(logic [OUT_DATA_W-1:0] got, output string why);
        logic [OUT_DATA_W-1:0] want;
        why = "";
        if (expected_q.size() == 0)
        begin
            why = $sformatf(" result %h with nothing expected", got);
            return 1'b0;
        end
        want = expected_q.pop_front();
        if (got[WORD_W-1:0] !== want[WORD_W-1:0])
            why = {why, $sformatf(" out_word0 %h, expected %h",
                                  got[WORD_W-1:0], want[WORD_W-1:0])};
        if (got[OUT_DATA_W-1:WORD_W] !== want[OUT_DATA_W-1:WORD_W])
            why = {why, $sformatf(" out_word1 %h, expected %h",
                                  got[OUT_DATA_W-1:WORD_W], want[OUT_DATA_W-1:WORD_W])};
        return why.len() == 0;
    endfunction
endclass

module tb;
    localparam int                ROUNDS       = ROUND_COUNT_DEF;
    localparam int                RANDOM_ITEMS = 700;
    localparam logic [REQ_W-1:0]  REQ_UNUSED   = 2'd3;
    localparam logic [WORD_W-1:0] ONES         = '1;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [REQ_W-1:0]      s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    ofb_scoreboard sb = new(ROUNDS);

    int    mismatches   = 0;
    int    results_seen = 0;
    int    blocks_sent  = 0;
    int    keys_sent    = 0;
    int    ivs_sent     = 0;
    int    ignored_sent = 0;
    int    burst_left   = 0;
    int    stall_cycle  = 0;
    string mismatch_text;

    speck128_ofb_block_cipher #(
        .ROUND_COUNT(ROUNDS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 clk = ~clk;

    task automatic report(input string what);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH at %0t:%s", $time, what);
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        logic [WORD_W-1:0] one_hot;
        one_hot = 64'd1 << $urandom_range(0, WORD_W - 1);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ONES;
            2:       return one_hot;
            3:       return ~one_hot;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [KEY_IDX_W-1:0] rand_slot();
        return KEY_IDX_W'($urandom_range(0, KEY_SLOTS - 1));
    endfunction

    task automatic send_item(input logic [REQ_W-1:0] req, input logic [KEY_IDX_W-1:0] slot,
                             input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, w1, w0, slot};
        s_axis_tuser  <= req;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(req, slot, w0, w1);
        case (req)
            REQ_LOAD_KEY: keys_sent++;
            REQ_LOAD_IV:  ivs_sent++;
            REQ_BLOCK:    blocks_sent++;
            default:      ignored_sent++;
        endcase
    endtask

    // bursts of random length; some bursts run with no gap at all
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (!sb.check_result(m_axis_tdata, mismatch_text))
                report(mismatch_text);
        end
        stall_cycle++;
        case (stall_cycle[9:8])
            2'd0:    m_axis_tready <= 1'b1;
            2'd1:    m_axis_tready <= ($urandom_range(0, 3) != 0);
            2'd2:    m_axis_tready <= ($urandom_range(0, 1) == 1);
            default: m_axis_tready <= ((stall_cycle % 48) >= 40);
        endcase
    end

    initial
    begin
        #10_000_000;
        $display("FAIL speck128_ofb_block_cipher");
        $finish;
    end

    initial
    begin
        int counted;
        int pick;
        counted = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every key slot before any block
        for (int i = 0; i < KEY_SLOTS; i++)
            send_item(REQ_LOAD_KEY, i[KEY_IDX_W-1:0],
                      (i == 0) ? ONES : (i == KEY_SLOTS - 1) ? '0 : rand_word(), rand_word());

        // feedback still at its reset value
        send_item(REQ_BLOCK, '0, '0, '0);
        send_item(REQ_BLOCK, '1, ONES, ONES);
        send_item(REQ_UNUSED, '1, ONES, ONES);
        send_item(REQ_BLOCK, '0, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
        send_item(REQ_LOAD_IV, '0, ONES, ONES);
        send_item(REQ_BLOCK, '0, {16{4'h5}}, {16{4'ha}});
        send_item(REQ_LOAD_IV, '1, '0, '0);
        send_item(REQ_BLOCK, '0, '0, '0);
        send_item(REQ_LOAD_KEY, '1, ONES, '0);
        send_item(REQ_LOAD_KEY, '0, '0, ONES);
        send_item(REQ_BLOCK, '0, ONES, '0);
        send_item(REQ_LOAD_IV, '0, {16{4'ha}}, {16{4'h5}});
        send_item(REQ_UNUSED, '0, '0, '0);
        send_item(REQ_BLOCK, '0, '0, ONES);
        send_item(REQ_BLOCK, '0, rand_word(), rand_word());
        send_item(REQ_BLOCK, '0, rand_word(), rand_word());
        drain();

        while (counted < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                send_item(REQ_UNUSED, rand_slot(), rand_word(), rand_word());
            else
            begin
                if (pick < 20)
                    send_item(REQ_LOAD_KEY, rand_slot(), rand_word(), rand_word());
                else if (pick < 30)
                    send_item(REQ_LOAD_IV, rand_slot(), rand_word(), rand_word());
                else
                    send_item(REQ_BLOCK, rand_slot(), rand_word(), rand_word());
                counted++;
            end
            pace_sender();
            if (counted % 150 == 149)
                drain();
        end

        drain();
        repeat (ROUNDS + 8) @(posedge clk);

        $display("Covered %0d blocks, %0d key loads, %0d IV loads, %0d unused-code items",
                 blocks_sent, keys_sent, ivs_sent, ignored_sent);
        $display("Compared %0d results, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0)
            $display("PASS speck128_ofb_block_cipher");
        else
            $display("FAIL speck128_ofb_block_cipher");
        $finish;
    end
endmodule

@@ speck128_ofb_block_cipher.f @@
+incdir+rtl
rtl/speck_ofb_pkg.sv
rtl/speck_ofb_round.sv
rtl/speck128_ofb_block_cipher.sv
tb/sv/tb.sv
